FILE: hw/rtl/fvtp_pkg.sv
package fvtp_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int FRAME_BYTES   = 8;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int CFG_IDX_W     = 2;
  localparam int BYTE_W        = 8;
  localparam int ENTRY_W       = 16;
  localparam int SUM_W         = 24;

  // last byte positions of the two frame kinds
  localparam logic [POS_W-1:0] VALUE_LAST_POS = POS_W'(3);
  localparam logic [POS_W-1:0] INFO_LAST_POS  = POS_W'(7);

  // report kinds
  localparam logic [1:0] KIND_SHOW_ALL = 2'd0;
  localparam logic [1:0] KIND_SHOW_ONE = 2'd1;
  localparam logic [1:0] KIND_OTHER    = 2'd2;
  localparam logic [1:0] KIND_WRONG    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ALL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ONE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_LO = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ONE   = 5'b00100,
    S_SUM   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

endpackage

FILE: hw/rtl/framed_value_table_parser.sv
// framed value table parser
// start/busy command channel: one received byte (rx_byte) is taken at a
// rising edge where start is high and busy is low. bytes build frames whose
// first byte is a message id. a value frame (id, index, high, low) writes a
// 16-bit entry of a 256-entry table and gives no report. an eight-byte info
// frame gives one report; an id other than the value id at or above
// invalid_id_bound reports a wrong id at once and framing restarts.
// reports come out on registered ports, marked by done for exactly one
// cycle; the receiver cannot stall them.
// per item: a byte that gives no report leaves busy low. an other-id or
// wrong-id report is registered in the cycle after its byte. a show-one
// report passes through S_ONE (one table read). a show-all report passes
// through S_SUM and S_FIN: a single 24-bit adder accumulates the table
// one entry per cycle through the single registered table read port.
// reset: configuration registers go to their defaults, framing restarts,
// and a clearing pass writes zero to all 256 table entries, one per cycle,
// with busy high throughout. configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once and are taken at any time.
module framed_value_table_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       rx_byte,
  input  logic                             cfg_we,
  input  logic [fvtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data,
  output logic                             done,
  output logic [1:0]                       report_kind,
  output logic [7:0]                       report_index,
  output logic [23:0]                      report_value,
  output logic [15:0]                      info_short,
  output logic [31:0]                      info_long
);
  import fvtp_pkg::*;

  // configuration
  logic [BYTE_W-1:0] value_frame_id;
  logic [BYTE_W-1:0] show_all_id;
  logic [BYTE_W-1:0] show_one_id;
  logic [BYTE_W-1:0] invalid_id_bound;

  // framing
  logic [BYTE_W-1:0] frame_store [FRAME_BYTES];
  logic [POS_W-1:0]  frame_position;

  // table memory, one write and one registered read port
  logic [ENTRY_W-1:0] value_table [TABLE_ENTRIES];
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_waddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [TBL_AW-1:0]  tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;

  // sequencer
  state_t            state;
  logic [TBL_AW-1:0] cnt;
  logic              rd_pend;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  add_out;

  // decode of the current byte
  logic              accept;
  logic [BYTE_W-1:0] cur_id;
  logic [BYTE_W-1:0] cur_lo;
  logic              is_value;
  logic              is_valid;
  logic              value_done;
  logic              info_done;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // the current byte lands at frame_position, so the id and the low value
  // byte may come straight from the input
  assign cur_id     = (frame_position == '0) ? rx_byte : frame_store[0];
  assign cur_lo     = (frame_position == VALUE_LAST_POS) ? rx_byte : frame_store[3];
  assign is_value   = (cur_id == value_frame_id);
  assign is_valid   = (cur_id < invalid_id_bound);
  assign value_done = is_value && (frame_position >= VALUE_LAST_POS);
  assign info_done  = !is_value && is_valid && (frame_position == INFO_LAST_POS);

  // the single adder, used for the show-all sum
  assign add_out = acc + {{(SUM_W-ENTRY_W){1'b0}}, tbl_rdata};

  // table write port: clearing pass or value frame
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = frame_store[1];
    tbl_wdata = {frame_store[2], cur_lo};
    if (state == S_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = cnt;
      tbl_wdata = '0;
    end else if (accept && value_done) begin
      tbl_we = 1'b1;
    end
  end

  // read port: sweep address while summing, else the frame's index byte
  assign tbl_raddr = (state == S_SUM) ? cnt : frame_store[1];

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      value_table[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= value_table[tbl_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      value_frame_id   <= 8'd0;
      show_all_id      <= 8'd1;
      show_one_id      <= 8'd2;
      invalid_id_bound <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALUE_ID:   value_frame_id   <= cfg_data;
        REG_SHOW_ALL:   show_all_id      <= cfg_data;
        REG_SHOW_ONE:   show_one_id      <= cfg_data;
        REG_INVALID_LO: invalid_id_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame store, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_store[frame_position] <= rx_byte;
    end
  end

  // sequencer and report registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      cnt            <= '0;
      frame_position <= '0;
      rd_pend        <= 1'b0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == TBL_AW'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (value_done || (is_value && !value_done)) begin
              // value frame in progress or done; no report
              frame_position <= value_done ? '0 : frame_position + 1'b1;
            end else if (!is_valid) begin
              // wrong id: immediate zero report, restart framing
              frame_position <= '0;
              done           <= 1'b1;
              report_kind    <= KIND_WRONG;
              report_index   <= '0;
              report_value   <= '0;
              info_short     <= '0;
              info_long      <= '0;
            end else if (!info_done) begin
              frame_position <= frame_position + 1'b1;
            end else begin
              frame_position <= '0;
              if (cur_id == show_all_id) begin
                state   <= S_SUM;
                cnt     <= '0;
                acc     <= '0;
                rd_pend <= 1'b0;
              end else if (cur_id == show_one_id) begin
                // index already on the read address
                state <= S_ONE;
              end else begin
                done         <= 1'b1;
                report_kind  <= KIND_OTHER;
                report_index <= frame_store[1];
                report_value <= '0;
                info_short   <= {frame_store[2], frame_store[3]};
                info_long    <= {frame_store[4], frame_store[5], frame_store[6], rx_byte};
              end
            end
          end
        end
        S_ONE: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          report_kind  <= KIND_SHOW_ONE;
          report_index <= frame_store[1];
          report_value <= {{(SUM_W-ENTRY_W){1'b0}}, tbl_rdata};
          info_short   <= {frame_store[2], frame_store[3]};
          info_long    <= {frame_store[4], frame_store[5], frame_store[6], frame_store[7]};
        end
        S_SUM: begin
          // read data is registered, so it trails the address
          rd_pend <= 1'b1;
          if (rd_pend) begin
            acc <= add_out;
          end
          cnt <= cnt + 1'b1;
          if (cnt == TBL_AW'(TABLE_ENTRIES - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // last entry joins the sum here
          state        <= S_IDLE;
          rd_pend      <= 1'b0;
          done         <= 1'b1;
          report_kind  <= KIND_SHOW_ALL;
          report_index <= frame_store[1];
          report_value <= add_out;
          info_short   <= {frame_store[2], frame_store[3]};
          info_long    <= {frame_store[4], frame_store[5], frame_store[6], frame_store[7]};
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_framed_value_table_parser.sv
`timescale 1ns / 1ps

module tb_framed_value_table_parser;
  import fvtp_pkg::*;

  // run sizing
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int PHASE_ITEMS  = 150;
  localparam int LAST_PHASE   = 8;
  localparam int SETTLE_WAIT  = 4;
  localparam int RECENT_DEPTH = 16;

  // opening stream under reset settings (value id 0, show all 1, show one 2, bound 3):
  // show-all on the cleared table, a write of 0xffff to entry 0xff, show-one of
  // that entry, a wrong id at the top of the byte range and one right at the bound
  localparam logic [7:0] OPENING [22] = '{
    8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'hFF, 8'hFF, 8'hFF,
    8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'h03
  };

  // one report as it appears on the result ports
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [23:0] value;
    logic [15:0] short_word;
    logic [31:0] long_word;
  } report_t;

  // one received byte and the report it should cause
  typedef struct {
    logic [7:0] data;
    bit         has_report;
    report_t    rep;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  rx_byte = '0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        done;
  logic [1:0]  report_kind;
  logic [7:0]  report_index;
  logic [23:0] report_value;
  logic [15:0] info_short;
  logic [31:0] info_long;

  // parser image: registers, frame assembly and the value table
  logic [7:0]  cfg_vid;
  logic [7:0]  cfg_all;
  logic [7:0]  cfg_one;
  logic [7:0]  cfg_bound;
  logic [7:0]  frm [FRAME_BYTES];
  logic [2:0]  frm_pos;
  logic [15:0] vtable [TABLE_ENTRIES];

  rx_item_t    rx_items [$];
  report_t     reports_due [$];
  logic [7:0]  recent_idx [$];
  rx_item_t    head_item;
  report_t     seen_rep;
  report_t     due_rep;
  int          idle_left = 0;
  bit          no_gaps = 1'b0;
  int          bytes_made = 0;
  int          errors = 0;
  int          cycles = 0;

  framed_value_table_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .rx_byte      (rx_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .report_kind  (report_kind),
    .report_index (report_index),
    .report_value (report_value),
    .info_short   (info_short),
    .info_long    (info_long)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // advance the parser image by one byte; returns 1 when a report is due
  function automatic bit parse_byte(input logic [7:0] b, output report_t rep);
    logic [2:0]  p;
    logic [7:0]  id;
    logic [23:0] acc;
    int          i;
    p = frm_pos;
    frm[p] = b;
    id = frm[0];
    rep = '0;
    // value id is checked first, so it wins even at or above the bound
    if (id == cfg_vid) begin
      if (p >= VALUE_LAST_POS) begin
        // a value frame at position three or later completes right away
        vtable[frm[1]] = {frm[2], frm[3]};
        frm_pos = '0;
      end else begin
        frm_pos = p + 3'd1;
      end
      return 1'b0;
    end
    if (id >= cfg_bound) begin
      // wrong id: all fields zero and framing restarts
      rep.kind = KIND_WRONG;
      frm_pos = '0;
      return 1'b1;
    end
    if (p != INFO_LAST_POS) begin
      frm_pos = p + 3'd1;
      return 1'b0;
    end
    rep.index      = frm[1];
    rep.short_word = {frm[2], frm[3]};
    rep.long_word  = {frm[4], frm[5], frm[6], frm[7]};
    // show-all takes priority over show-one when both ids match
    if (id == cfg_all) begin
      acc = '0;
      for (i = 0; i < TABLE_ENTRIES; i++) acc = acc + 24'(vtable[i]);
      rep.kind  = KIND_SHOW_ALL;
      rep.value = acc;
    end else if (id == cfg_one) begin
      rep.kind  = KIND_SHOW_ONE;
      rep.value = 24'(vtable[frm[1]]);
    end else begin
      rep.kind = KIND_OTHER;
    end
    frm_pos = '0;
    return 1'b1;
  endfunction

  function automatic string fmt_report(input report_t r);
    return $sformatf("kind %0d index %02h value %06h short %04h long %08h",
                     r.kind, r.index, r.value, r.short_word, r.long_word);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // queue one byte for the driver along with its predicted report
  task automatic send_byte(input logic [7:0] b);
    rx_item_t it;
    it.data = b;
    it.has_report = parse_byte(b, it.rep);
    rx_items.push_back(it);
    bytes_made++;
  endtask

  // choose an id that opens an info frame under the current settings
  function automatic bit pick_info_id(output logic [7:0] id);
    int r;
    int tries;
    r = $urandom_range(0, 99);
    id = '0;
    if (cfg_bound == 8'd0) return 1'b0;
    if (r < 15 && cfg_all < cfg_bound && cfg_all != cfg_vid) begin
      id = cfg_all;
      return 1'b1;
    end
    if (r < 50 && cfg_one < cfg_bound && cfg_one != cfg_vid) begin
      id = cfg_one;
      return 1'b1;
    end
    for (tries = 0; tries < 8; tries++) begin
      id = 8'($urandom_range(0, cfg_bound - 1));
      if (id != cfg_vid) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_index();
    if (recent_idx.size() != 0 && $urandom_range(0, 1) == 0)
      return recent_idx[$urandom_range(0, recent_idx.size() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed frames with random content, some wrong ids and noise;
  // optionally leaves a frame half built so the next settings land mid-frame
  task automatic fill_phase(input int budget, input bit leave_open);
    int          stop_at;
    int          r;
    int          n;
    int          k;
    logic [7:0]  id;
    logic [7:0]  idx;
    logic [15:0] val;
    stop_at = bytes_made + budget;
    while (bytes_made < stop_at) begin
      r = $urandom_range(0, 99);
      if (frm_pos != 0) begin
        // finish whatever frame is open with random content
        send_byte(8'($urandom_range(0, 255)));
      end else if (r < 35) begin
        idx = pick_index();
        case ($urandom_range(0, 3))
          0, 1:    val = 16'hFFFF;
          2:       val = 16'h0000;
          default: val = 16'($urandom_range(0, 65535));
        endcase
        send_byte(cfg_vid);
        send_byte(idx);
        send_byte(val[15:8]);
        send_byte(val[7:0]);
        recent_idx.push_back(idx);
        if (recent_idx.size() > RECENT_DEPTH) void'(recent_idx.pop_front());
      end else if (r < 70 && pick_info_id(id)) begin
        send_byte(id);
        send_byte(pick_index());
        for (k = 0; k < FRAME_BYTES - 2; k++) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 85) begin
        // wrong id somewhere at or above the bound
        send_byte(8'($urandom_range(cfg_bound, 255)));
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
      end
    end
    if (leave_open && $urandom_range(0, 1) == 1) begin
      if (pick_info_id(id)) begin
        send_byte(id);
        n = $urandom_range(0, 5);
      end else begin
        send_byte(cfg_vid);
        n = $urandom_range(0, 2);
      end
      for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // sampled on the falling edge so that posedge updates have all settled
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_items.size() != 0 || start || reports_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_VALUE_ID:   cfg_vid   = v;
      REG_SHOW_ALL:   cfg_all   = v;
      REG_SHOW_ONE:   cfg_one   = v;
      REG_INVALID_LO: cfg_bound = v;
      default: ;
    endcase
  endtask

  // settings per phase: a few fixed corners, then random ones
  task automatic program_phase(input int ph);
    logic [7:0] v_id;
    logic [7:0] a_id;
    logic [7:0] o_id;
    logic [7:0] bnd;
    case (ph)
      // value id at the very top, almost every other id an info frame
      1: {v_id, a_id, o_id, bnd} = {8'hFF, 8'h00, 8'h01, 8'hFF};
      // show-all and show-one share an id
      2: {v_id, a_id, o_id, bnd} = {8'h10, 8'h20, 8'h20, 8'h80};
      // bound at zero: every id but the value id is wrong
      3: {v_id, a_id, o_id, bnd} = {8'h00, 8'h05, 8'h06, 8'h00};
      // value id above the bound, show-all id rejected as wrong
      4: {v_id, a_id, o_id, bnd} = {8'hC0, 8'h7F, 8'h03, 8'h40};
      default: begin
        bnd  = 8'($urandom_range(0, 255));
        a_id = (bnd != 0) ? 8'($urandom_range(0, bnd - 1)) : 8'($urandom_range(0, 255));
        o_id = (bnd != 0) ? 8'($urandom_range(0, bnd - 1)) : 8'($urandom_range(0, 255));
        v_id = 8'($urandom_range(0, 255));
        // turn a half-built frame into a value frame under the new settings
        if (frm_pos != 0 && $urandom_range(0, 1) == 1) v_id = frm[0];
      end
    endcase
    write_reg(REG_VALUE_ID, v_id);
    write_reg(REG_SHOW_ALL, a_id);
    write_reg(REG_SHOW_ONE, o_id);
    write_reg(REG_INVALID_LO, bnd);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: offers queued items, holds each while busy, random gaps between
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // item taken at this edge, its report becomes due
        if (head_item.has_report) reports_due.push_back(head_item.rep);
        // occasionally switch between gapped and back-to-back stretches
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        idle_left = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (rx_items.size() != 0) begin
          head_item = rx_items.pop_front();
          start   <= 1'b1;
          rx_byte <= head_item.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done pulse must match the oldest due report
  always @(posedge clk) begin
    if (!rst && done) begin
      seen_rep = {report_kind, report_index, report_value, info_short, info_long};
      if (reports_due.size() == 0) begin
        note_error($sformatf("unexpected report: %s", fmt_report(seen_rep)));
      end else begin
        due_rep = reports_due.pop_front();
        if (seen_rep !== due_rep)
          note_error($sformatf("report mismatch: expected %s, got %s",
                               fmt_report(due_rep), fmt_report(seen_rep)));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ph;
    // parser image after reset
    cfg_vid   = 8'd0;
    cfg_all   = 8'd1;
    cfg_one   = 8'd2;
    cfg_bound = 8'd3;
    frm_pos   = '0;
    foreach (frm[i]) frm[i] = '0;
    foreach (vtable[i]) vtable[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // the table clearing pass is covered by the driver waiting out busy
    foreach (OPENING[i]) send_byte(OPENING[i]);
    for (ph = 0; ph <= LAST_PHASE; ph++) begin
      if (ph > 0) begin
        wait_drained();
        // a trailing value write may still be in flight
        repeat (SETTLE_WAIT) @(posedge clk);
        program_phase(ph);
      end
      fill_phase(PHASE_ITEMS, ph != LAST_PHASE);
    end

    wait_drained();
    repeat (SETTLE_WAIT * 2) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
